FILE: rtl/lpca_pkg.sv
// shared constants, types and codes of the lagged pair co-occurrence accumulator
`default_nettype none
package lpca_pkg;

  localparam int MAX_SPACING = 32;
  localparam int LAG_W       = 5;
  localparam int CFG_W       = 6;
  localparam int PROB_W      = 17;
  localparam int KIND_W      = 2;
  localparam int ACC_W       = 64;
  localparam int TERM_W      = 2 * PROB_W;

  localparam logic [CFG_W-1:0]  SPC_RESET = CFG_W'(32);
  localparam logic [PROB_W-1:0] ONE_Q16   = PROB_W'(65536);
  localparam logic [TERM_W-1:0] ONE_Q32   = TERM_W'(64'h1_0000_0000);

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_DUMP  = 3'b100
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              shift;
    logic              mend;
    logic              use_smp;
    logic [PROB_W-1:0] q;
    logic              clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ACC_W-1:0] aa;
    logic [ACC_W-1:0] ap;
    logic [ACC_W-1:0] pa;
    logic [ACC_W-1:0] pp;
  } acc_row_t;

endpackage
`default_nettype wire

FILE: rtl/lpca_if.sv
// valid/ready channel interfaces for sample input and dump rows
`default_nettype none
interface lpca_in_if;
  logic                       valid;
  logic                       ready;
  logic [lpca_pkg::KIND_W-1:0] kind;
  logic [lpca_pkg::PROB_W-1:0] prob;
  logic                       missing;
  logic                       molecule_end;

  modport source (output valid, kind, prob, missing, molecule_end, input ready);
  modport sink   (input valid, kind, prob, missing, molecule_end, output ready);
endinterface

interface lpca_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpca_pkg::LAG_W-1:0]  lag_index;
  logic [lpca_pkg::ACC_W-1:0]  sum_acc_acc;
  logic [lpca_pkg::ACC_W-1:0]  sum_acc_prot;
  logic [lpca_pkg::ACC_W-1:0]  sum_prot_acc;
  logic [lpca_pkg::ACC_W-1:0]  sum_prot_prot;
  logic                        last_row;

  modport source (output valid, lag_index, sum_acc_acc, sum_acc_prot, sum_prot_acc,
                  sum_prot_prot, last_row, input ready);
  modport sink   (input valid, lag_index, sum_acc_acc, sum_acc_prot, sum_prot_acc,
                  sum_prot_prot, last_row, output ready);
endinterface
`default_nettype wire

FILE: rtl/lpca_cell.sv
// one lag cell: history tap, product pipeline and four saturating accumulators
`default_nettype none
module lpca_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpca_pkg::cell_ctrl_t        ctrl,
  input  logic                        lag_on,
  input  logic [lpca_pkg::PROB_W-1:0] left_p,
  input  logic                        left_u,
  output logic [lpca_pkg::PROB_W-1:0] hist_p,
  output logic                        hist_u,
  output lpca_pkg::acc_row_t          acc
);

  logic [lpca_pkg::PROB_W-1:0] h_p_r;
  logic                        h_u_r;

  logic                        a_en_r;
  logic [lpca_pkg::PROB_W-1:0] a_p_r;
  logic [lpca_pkg::PROB_W-1:0] a_q_r;

  logic                        b_en_r;
  logic [lpca_pkg::TERM_W-1:0] b_pq_r;
  logic [lpca_pkg::PROB_W-1:0] b_p_r;
  logic [lpca_pkg::PROB_W-1:0] b_q_r;

  logic                        c_en_r;
  logic [lpca_pkg::TERM_W-1:0] c_aa_r;
  logic [lpca_pkg::TERM_W-1:0] c_ap_r;
  logic [lpca_pkg::TERM_W-1:0] c_pa_r;
  logic [lpca_pkg::TERM_W-1:0] c_pp_r;

  logic [lpca_pkg::TERM_W-1:0] ps;
  logic [lpca_pkg::TERM_W-1:0] qs;

  lpca_pkg::acc_row_t acc_r;
  lpca_pkg::acc_row_t acc_nxt;

  // history tap: the newer neighbour's word moves in on every sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_u_r <= 1'b0;
    end else if (ctrl.shift) begin
      h_u_r <= ctrl.mend ? 1'b0 : left_u;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      h_p_r <= left_p;
    end
  end

  assign hist_p = h_p_r;
  assign hist_u = h_u_r;

  // pipeline enables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_en_r <= 1'b0;
      b_en_r <= 1'b0;
      c_en_r <= 1'b0;
    end else begin
      a_en_r <= ctrl.shift && ctrl.use_smp && left_u && lag_on;
      b_en_r <= a_en_r;
      c_en_r <= b_en_r;
    end
  end

  assign ps = {1'b0, b_p_r, 16'b0};
  assign qs = {1'b0, b_q_r, 16'b0};

  always_ff @(posedge clk) begin
    a_p_r  <= left_p;
    a_q_r  <= ctrl.q;
    b_pq_r <= a_p_r * a_q_r;
    b_p_r  <= a_p_r;
    b_q_r  <= a_q_r;
    // complements follow from p*q and the shifted operands
    c_aa_r <= b_pq_r;
    c_ap_r <= ps - b_pq_r;
    c_pa_r <= qs - b_pq_r;
    c_pp_r <= lpca_pkg::ONE_Q32 - ps - qs + b_pq_r;
  end

  function automatic logic [lpca_pkg::ACC_W-1:0] sat_add(
    input logic [lpca_pkg::ACC_W-1:0]  a,
    input logic [lpca_pkg::TERM_W-1:0] t
  );
    logic [lpca_pkg::ACC_W:0] s;
    s = {1'b0, a} + {{(lpca_pkg::ACC_W + 1 - lpca_pkg::TERM_W){1'b0}}, t};
    return s[lpca_pkg::ACC_W] ? {lpca_pkg::ACC_W{1'b1}} : s[lpca_pkg::ACC_W-1:0];
  endfunction

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (c_en_r) begin
      acc_nxt.aa = sat_add(acc_r.aa, c_aa_r);
      acc_nxt.ap = sat_add(acc_r.ap, c_ap_r);
      acc_nxt.pa = sat_add(acc_r.pa, c_pa_r);
      acc_nxt.pp = sat_add(acc_r.pp, c_pp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

FILE: rtl/lagged_pair_cooccurrence_accumulator.sv
// top level: sequencer, lag cell chain and dump row output register
// Usage:
//   in_ch carries one word per item: a sample (probability in Q1.16, missing and
//   molecule-end flags), a dump request or a clear request. out_ch carries the
//   dump rows, one per lag in use, lag 0 first, last_row set on the final one.
//   cfg_we/cfg_wdata set the number of lags in use; write only while idle.
// Throughput and pipeline:
//   samples are taken one per cycle while idle; each lag cell multiplies, forms
//   the four terms and accumulates over a four-stage pipeline of operand,
//   product, term and accumulator registers. A dump or clear first lets that
//   pipeline drain; then a clear zeroes all sums, or a dump loads one row per
//   cycle into the output register while out_ch can take it, n rows in all.
//   No input word is taken while a dump or clear is in progress.
// Reset (rst_n, synchronous): history emptied, all sums zero, 32 lags in use.
// Stall: when out_ch.ready is low the current row holds in the output
//   register and the row counter waits; samples are unaffected between dumps.
`default_nettype none
module lagged_pair_cooccurrence_accumulator (
  input  logic                       clk,
  input  logic                       rst_n,
  lpca_in_if.sink                    in_ch,
  lpca_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [lpca_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int N = lpca_pkg::MAX_SPACING;

  logic [lpca_pkg::CFG_W-1:0] spc_r;
  logic [lpca_pkg::CFG_W-1:0] n_lags;
  logic [N-1:0]               lag_on;

  lpca_pkg::state_t state_r;
  lpca_pkg::state_t state_nxt;
  logic             pend_dump_r;
  logic             pend_dump_nxt;
  logic [lpca_pkg::LAG_W-1:0] cnt_r;
  logic [lpca_pkg::LAG_W-1:0] cnt_nxt;

  logic v_a_r;
  logic v_b_r;
  logic v_c_r;
  logic pipe_busy;

  logic in_acc;
  logic row_load;
  logic row_last;
  logic clr;
  logic [lpca_pkg::PROB_W-1:0] q_clamp;

  lpca_pkg::cell_ctrl_t ctrl;

  logic [lpca_pkg::PROB_W-1:0] chain_p [0:N];
  logic                        chain_u [0:N];
  lpca_pkg::acc_row_t          rows    [0:N-1];

  logic                        out_vld_r;
  logic [lpca_pkg::LAG_W-1:0]  out_lag_r;
  lpca_pkg::acc_row_t          out_row_r;
  logic                        out_last_r;

  // lag count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= lpca_pkg::SPC_RESET;
    end else if (cfg_we) begin
      spc_r <= cfg_wdata;
    end
  end

  always_comb begin
    n_lags = spc_r;
    if (spc_r == '0) begin
      n_lags = lpca_pkg::CFG_W'(1);
    end else if (spc_r > lpca_pkg::CFG_W'(N)) begin
      n_lags = lpca_pkg::CFG_W'(N);
    end
  end

  assign in_ch.ready = (state_r == lpca_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign q_clamp     = (in_ch.prob > lpca_pkg::ONE_Q16) ? lpca_pkg::ONE_Q16 : in_ch.prob;

  assign ctrl.shift   = in_acc && (in_ch.kind == lpca_pkg::KIND_SAMPLE);
  assign ctrl.mend    = in_ch.molecule_end;
  assign ctrl.use_smp = !in_ch.missing;
  assign ctrl.q       = q_clamp;
  assign ctrl.clr     = clr;

  // samples in flight through the cell pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      v_a_r <= ctrl.shift;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
    end
  end

  assign pipe_busy = v_a_r || v_b_r || v_c_r;

  // lag 0 pairs the sample with itself
  assign chain_p[0] = q_clamp;
  assign chain_u[0] = !in_ch.missing;

  for (genvar k = 0; k < N; k++) begin : g_cell
    assign lag_on[k] = lpca_pkg::CFG_W'(k) < n_lags;

    lpca_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .lag_on (lag_on[k]),
      .left_p (chain_p[k]),
      .left_u (chain_u[k]),
      .hist_p (chain_p[k+1]),
      .hist_u (chain_u[k+1]),
      .acc    (rows[k])
    );
  end

  assign row_load = (state_r == lpca_pkg::ST_DUMP) && (!out_vld_r || out_ch.ready);
  assign row_last = ({1'b0, cnt_r} == (n_lags - lpca_pkg::CFG_W'(1)));

  always_comb begin
    state_nxt     = state_r;
    pend_dump_nxt = pend_dump_r;
    cnt_nxt       = cnt_r;
    clr           = 1'b0;
    unique case (state_r)
      lpca_pkg::ST_IDLE: begin
        if (in_acc && (in_ch.kind == lpca_pkg::KIND_DUMP)) begin
          pend_dump_nxt = 1'b1;
          state_nxt     = lpca_pkg::ST_DRAIN;
        end else if (in_acc && (in_ch.kind == lpca_pkg::KIND_CLEAR)) begin
          pend_dump_nxt = 1'b0;
          state_nxt     = lpca_pkg::ST_DRAIN;
        end
      end
      lpca_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          if (pend_dump_r) begin
            cnt_nxt   = '0;
            state_nxt = lpca_pkg::ST_DUMP;
          end else begin
            clr       = 1'b1;
            state_nxt = lpca_pkg::ST_IDLE;
          end
        end
      end
      lpca_pkg::ST_DUMP: begin
        if (row_load) begin
          cnt_nxt = cnt_r + lpca_pkg::LAG_W'(1);
          if (row_last) begin
            state_nxt = lpca_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lpca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpca_pkg::ST_IDLE;
      pend_dump_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_dump_r <= pend_dump_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // output register, takes the next row while the previous word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (row_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_load) begin
      out_lag_r  <= cnt_r;
      out_row_r  <= rows[cnt_r];
      out_last_r <= row_last;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.lag_index     = out_lag_r;
  assign out_ch.sum_acc_acc   = out_row_r.aa;
  assign out_ch.sum_acc_prot  = out_row_r.ap;
  assign out_ch.sum_prot_acc  = out_row_r.pa;
  assign out_ch.sum_prot_prot = out_row_r.pp;
  assign out_ch.last_row      = out_last_r;

`ifndef SYNTHESIS
  // rows are read only once every pending add has landed
  a_dump_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpca_pkg::ST_DUMP) |-> !pipe_busy)
    else $error("dump row read while accumulation in flight");

  a_clear_drained: assert property (@(posedge clk) disable iff (!rst_n)
    clr |-> !pipe_busy)
    else $error("clear issued while accumulation in flight");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_ch.lag_index} < n_lags))
    else $error("dump row beyond lags in use");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (row_load && !row_last) |=> (cnt_r == $past(cnt_r) + lpca_pkg::LAG_W'(1)))
    else $error("dump row counter skipped");
`endif

endmodule
`default_nettype wire
